// ===== hw/rtl/hnt_pkg.sv =====
`default_nettype none

package hnt_pkg;

    // Pool geometry.
    localparam int POOL_SIZE = 16;
    localparam int IDX_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int COUNT_W   = $clog2(POOL_SIZE + 1);
    localparam int HELD_W    = 5;
    localparam int HELD_EXT_W = COUNT_W + HELD_W;

    // Request kinds.
    localparam logic REQ_NOTE_ON  = 1'b0;
    localparam logic REQ_NOTE_OFF = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [6:0] pitch;
        logic [6:0] velocity;
        logic [3:0] channel;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [HELD_W-1:0] held_count;
        logic [6:0]        lowest_pitch;
        logic [6:0]        highest_pitch;
        logic [6:0]        newest_pitch;
        logic [6:0]        newest_velocity;
        logic [3:0]        newest_channel;
    } rsp_t;

    // One note slot; rank 0 is the oldest held note.
    typedef struct packed {
        logic             used;
        logic [6:0]       pitch;
        logic [6:0]       velocity;
        logic [3:0]       channel;
        logic [IDX_W-1:0] rank;
    } slot_t;

    // Write port of the slot store.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        slot_t            data;
    } slot_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPLY,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_REFRESH,
        OP_INSERT,
        OP_REMOVE
    } note_op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hnt_slot_store.sv =====
`default_nettype none

module hnt_slot_store (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [hnt_pkg::IDX_W-1:0] rd_idx,
    output hnt_pkg::slot_t                 rd_slot,
    input  hnt_pkg::slot_wr_t              wr
);

    hnt_pkg::slot_t slots_reg [hnt_pkg::POOL_SIZE];

    // Slot registers: cleared at reset, one slot written per cycle while the write enable is set.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hnt_pkg::POOL_SIZE; i++)
            begin
                slots_reg[i] <= '0;
            end
        end
        else if (wr.we)
        begin
            slots_reg[wr.idx] <= wr.data;
        end
    end

    // Scan read port.
    assign rd_slot = slots_reg[rd_idx];

endmodule

`default_nettype wire

// ===== hw/rtl/hnt_ctrl.sv =====
`default_nettype none

module hnt_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    input  hnt_pkg::req_t                  req_data,
    output logic                           req_stall,
    input  wire logic                      rsp_free,
    output logic                           res_valid,
    output hnt_pkg::rsp_t                  res_data,
    output logic [hnt_pkg::IDX_W-1:0]      rd_idx,
    input  hnt_pkg::slot_t                 rd_slot,
    output hnt_pkg::slot_wr_t              wr
);

    localparam logic [hnt_pkg::IDX_W-1:0]   LAST_IDX  = hnt_pkg::IDX_W'(hnt_pkg::POOL_SIZE - 1);
    localparam logic [hnt_pkg::COUNT_W-1:0] FULL_CNT  = hnt_pkg::COUNT_W'(hnt_pkg::POOL_SIZE);
    localparam logic [hnt_pkg::COUNT_W-1:0] CNT_ONE   = hnt_pkg::COUNT_W'(1);
    localparam logic [hnt_pkg::IDX_W-1:0]   RANK_ONE  = hnt_pkg::IDX_W'(1);

    hnt_pkg::ctrl_state_t state_reg, state_next;
    hnt_pkg::note_op_t    op_reg, op_next;
    hnt_pkg::req_t        req_reg, req_next;

    logic [hnt_pkg::IDX_W-1:0]   scan_reg, scan_next;
    logic                        found_reg, found_next;
    logic [hnt_pkg::IDX_W-1:0]   match_idx_reg, match_idx_next;
    logic [hnt_pkg::IDX_W-1:0]   match_rank_reg, match_rank_next;
    logic                        free_found_reg, free_found_next;
    logic [hnt_pkg::IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [hnt_pkg::IDX_W-1:0]   tgt_reg, tgt_next;
    logic [hnt_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        ok_reg, ok_next;
    logic                        any_reg, any_next;
    logic [6:0]                  lo_reg, lo_next;
    logic [6:0]                  hi_reg, hi_next;
    logic [6:0]                  np_reg, np_next;
    logic [6:0]                  nv_reg, nv_next;
    logic [3:0]                  nc_reg, nc_next;

    logic                        scan_last;
    logic [hnt_pkg::COUNT_W-1:0] count_new;
    logic [hnt_pkg::COUNT_W-1:0] count_m1;
    hnt_pkg::slot_t              slot_new;
    logic [hnt_pkg::HELD_EXT_W-1:0] held_ext;

    assign scan_last = (scan_reg == LAST_IDX);
    assign count_m1  = count_reg - CNT_ONE;

    // Count after the pending change takes effect.
    always_comb
    begin
        case (op_reg)
            hnt_pkg::OP_INSERT: count_new = count_reg + CNT_ONE;
            hnt_pkg::OP_REMOVE: count_new = count_m1;
            default:            count_new = count_reg;
        endcase
    end

    // Shared slot unit: new contents of the slot under the scan pointer.
    always_comb
    begin
        slot_new = rd_slot;
        case (op_reg)
            hnt_pkg::OP_REFRESH:
            begin
                if (scan_reg == tgt_reg)
                begin
                    slot_new.velocity = req_reg.velocity;
                    slot_new.channel  = req_reg.channel;
                    slot_new.rank     = count_m1[hnt_pkg::IDX_W-1:0];
                end
                else if (rd_slot.used && (rd_slot.rank > match_rank_reg))
                begin
                    slot_new.rank = rd_slot.rank - RANK_ONE;
                end
            end
            hnt_pkg::OP_REMOVE:
            begin
                if (scan_reg == tgt_reg)
                begin
                    slot_new = '0;
                end
                else if (rd_slot.used && (rd_slot.rank > match_rank_reg))
                begin
                    slot_new.rank = rd_slot.rank - RANK_ONE;
                end
            end
            hnt_pkg::OP_INSERT:
            begin
                if (scan_reg == tgt_reg)
                begin
                    slot_new.used     = 1'b1;
                    slot_new.pitch    = req_reg.pitch;
                    slot_new.velocity = req_reg.velocity;
                    slot_new.channel  = req_reg.channel;
                    slot_new.rank     = count_reg[hnt_pkg::IDX_W-1:0];
                end
            end
            default:
            begin
                slot_new = rd_slot;
            end
        endcase
    end

    // Datapath next values for the search and apply passes.
    always_comb
    begin
        req_next        = req_reg;
        op_next         = op_reg;
        scan_next       = scan_reg;
        found_next      = found_reg;
        match_idx_next  = match_idx_reg;
        match_rank_next = match_rank_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        tgt_next        = tgt_reg;
        count_next      = count_reg;
        ok_next         = ok_reg;
        any_next        = any_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        np_next         = np_reg;
        nv_next         = nv_reg;
        nc_next         = nc_reg;

        case (state_reg)
            hnt_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next        = req_data;
                    scan_next       = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            hnt_pkg::ST_SEARCH:
            begin
                // Look for the held pitch and for the lowest free slot.
                if (rd_slot.used && (rd_slot.pitch == req_reg.pitch) && !found_reg)
                begin
                    found_next      = 1'b1;
                    match_idx_next  = scan_reg;
                    match_rank_next = rd_slot.rank;
                end
                if (!rd_slot.used && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = scan_reg;
                end
                scan_next = scan_reg + RANK_ONE;
                if (scan_last)
                begin
                    // Decide the operation once the whole pool has been seen.
                    if (req_reg.req_type == hnt_pkg::REQ_NOTE_ON)
                    begin
                        if (found_next)
                        begin
                            op_next = hnt_pkg::OP_REFRESH;
                        end
                        else if ((count_reg < FULL_CNT) && free_found_next)
                        begin
                            op_next = hnt_pkg::OP_INSERT;
                        end
                        else
                        begin
                            op_next = hnt_pkg::OP_NONE;
                        end
                    end
                    else if (found_next)
                    begin
                        op_next = hnt_pkg::OP_REMOVE;
                    end
                    else
                    begin
                        op_next = hnt_pkg::OP_NONE;
                    end
                    ok_next   = (op_next != hnt_pkg::OP_NONE);
                    tgt_next  = found_next ? match_idx_next : free_idx_next;
                    scan_next = '0;
                    any_next  = 1'b0;
                    lo_next   = '0;
                    hi_next   = '0;
                    np_next   = '0;
                    nv_next   = '0;
                    nc_next   = '0;
                end
            end
            hnt_pkg::ST_APPLY:
            begin
                // Fold the updated slot into the pool summary.
                if (slot_new.used)
                begin
                    if (!any_reg || (slot_new.pitch < lo_reg))
                    begin
                        lo_next = slot_new.pitch;
                    end
                    if (!any_reg || (slot_new.pitch > hi_reg))
                    begin
                        hi_next = slot_new.pitch;
                    end
                    any_next = 1'b1;
                    if ((hnt_pkg::COUNT_W'(slot_new.rank) + CNT_ONE) == count_new)
                    begin
                        np_next = slot_new.pitch;
                        nv_next = slot_new.velocity;
                        nc_next = slot_new.channel;
                    end
                end
                scan_next = scan_reg + RANK_ONE;
                if (scan_last)
                begin
                    count_next = count_new;
                    scan_next  = '0;
                end
            end
            default:
            begin
                scan_next = scan_reg;
            end
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hnt_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = hnt_pkg::ST_SEARCH;
                end
            end
            hnt_pkg::ST_SEARCH:
            begin
                if (scan_last)
                begin
                    state_next = hnt_pkg::ST_APPLY;
                end
            end
            hnt_pkg::ST_APPLY:
            begin
                if (scan_last)
                begin
                    state_next = hnt_pkg::ST_DONE;
                end
            end
            hnt_pkg::ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = hnt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hnt_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        req_stall = (state_reg != hnt_pkg::ST_IDLE);
        res_valid = (state_reg == hnt_pkg::ST_DONE) && rsp_free;
        rd_idx    = scan_reg;
        wr.we     = (state_reg == hnt_pkg::ST_APPLY) && (op_reg != hnt_pkg::OP_NONE);
        wr.idx    = scan_reg;
        wr.data   = slot_new;
    end

    // Result fields; the count is masked to the field width.
    assign held_ext = hnt_pkg::HELD_EXT_W'(count_reg);

    always_comb
    begin
        res_data.ok              = ok_reg;
        res_data.held_count      = held_ext[hnt_pkg::HELD_W-1:0];
        res_data.lowest_pitch    = lo_reg;
        res_data.highest_pitch   = hi_reg;
        res_data.newest_pitch    = np_reg;
        res_data.newest_velocity = nv_reg;
        res_data.newest_channel  = nc_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hnt_pkg::ST_IDLE;
            scan_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            count_reg <= count_next;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        op_reg         <= op_next;
        found_reg      <= found_next;
        match_idx_reg  <= match_idx_next;
        match_rank_reg <= match_rank_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        tgt_reg        <= tgt_next;
        ok_reg         <= ok_next;
        any_reg        <= any_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        np_reg         <= np_next;
        nv_reg         <= nv_next;
        nc_reg         <= nc_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/held_note_tracker_top.sv =====
// A request is handled in two passes over the slots once it is accepted:
// one pass over the slots searches, a second pass updates and summarizes them.
// A new request is taken only after both passes over the single slot read port are done and
// the result has entered the response register; a stalled response delays this.
// The request side stalls while a request is in flight.
// Reset is asynchronous, active low, and empties the note pool and the response register.
`default_nettype none

module held_note_tracker_top (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_stall,
    input  hnt_pkg::req_t req_data,
    output logic         rsp_valid,
    input  wire logic    rsp_stall,
    output hnt_pkg::rsp_t rsp_data
);

    logic                      rsp_valid_reg;
    hnt_pkg::rsp_t             rsp_data_reg;
    logic                      rsp_free;
    logic                      res_valid;
    hnt_pkg::rsp_t             res_data;
    logic [hnt_pkg::IDX_W-1:0] rd_idx;
    hnt_pkg::slot_t            rd_slot;
    hnt_pkg::slot_wr_t         wr;

    // The response register can take a new result when empty or being drained.
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    hnt_slot_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (rd_idx),
        .rd_slot (rd_slot),
        .wr      (wr)
    );

    hnt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_data  (req_data),
        .req_stall (req_stall),
        .rsp_free  (rsp_free),
        .res_valid (res_valid),
        .res_data  (res_data),
        .rd_idx    (rd_idx),
        .rd_slot   (rd_slot),
        .wr        (wr)
    );

    // Response valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_data_reg <= res_data;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hnt_checker.sv =====
`default_nettype none

module hnt_checker (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    input  wire logic     req_stall,
    input  hnt_pkg::req_t req_data,
    input  wire logic     rsp_valid,
    input  wire logic     rsp_stall,
    input  hnt_pkg::rsp_t rsp_data
);

    // A stalled response holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed");

    // One request at a time: an accepted request blocks the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
    else $error("request accepted while another is in flight");

    // The range of held pitches is never inverted.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.lowest_pitch <= rsp_data.highest_pitch)
    else $error("lowest pitch above highest pitch");

    // An empty pool reports a zero highest pitch and zero newest note fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.held_count == '0) |->
            (rsp_data.highest_pitch == '0) && (rsp_data.newest_pitch == '0) &&
            (rsp_data.newest_velocity == '0) && (rsp_data.newest_channel == '0))
    else $error("empty pool reports a note");

    // A stalled request stays valid and unchanged until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_data))
    else $error("stalled request changed");

endmodule

bind held_note_tracker_top hnt_checker u_hnt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

// Scoreboard for the held note pool: it mirrors the slots, predicts one response
// per accepted request and checks the responses in order.
class note_board;
    bit               slot_busy[hnt_pkg::POOL_SIZE];
    logic [6:0]       slot_note[hnt_pkg::POOL_SIZE];
    logic [6:0]       slot_vel[hnt_pkg::POOL_SIZE];
    logic [3:0]       slot_chan[hnt_pkg::POOL_SIZE];
    int               slot_age[hnt_pkg::POOL_SIZE];
    int               held;
    hnt_pkg::rsp_t    pending_rsp[$];
    int               errors;
    int               n_checked;
    int               n_requests;
    int               n_insert;
    int               n_refresh;
    int               n_full_reject;
    int               n_remove;
    int               n_miss;

    function new();
        for (int i = 0; i < hnt_pkg::POOL_SIZE; i++)
        begin
            slot_busy[i] = 1'b0;
            slot_note[i] = '0;
            slot_vel[i]  = '0;
            slot_chan[i] = '0;
            slot_age[i]  = 0;
        end
        held = 0;
    endfunction

    // Close the gap in the trigger order left by the rank that is leaving.
    function void close_age_gap(int leaving);
        for (int i = 0; i < hnt_pkg::POOL_SIZE; i++)
        begin
            if (slot_busy[i] && slot_age[i] > leaving)
                slot_age[i]--;
        end
    endfunction

    // Apply one accepted request to the mirror and queue the response it must give.
    function void note_request(hnt_pkg::req_t r);
        int            slot;
        int            leaving;
        bit            any;
        bit            done;
        hnt_pkg::rsp_t want;
        slot = -1;
        want = '0;
        n_requests++;
        for (int i = hnt_pkg::POOL_SIZE - 1; i >= 0; i--)
        begin
            if (slot_busy[i] && slot_note[i] == r.pitch)
                slot = i;
        end

        if (r.req_type == hnt_pkg::REQ_NOTE_ON)
        begin
            if (slot >= 0)
            begin
                // A held pitch is refreshed and becomes the newest note.
                slot_vel[slot]  = r.velocity;
                slot_chan[slot] = r.channel;
                close_age_gap(slot_age[slot]);
                slot_age[slot]  = held - 1;
                want.ok = 1'b1;
                n_refresh++;
            end
            else if (held < hnt_pkg::POOL_SIZE)
            begin
                // A new pitch takes the lowest free slot.
                done = 1'b0;
                for (int i = 0; i < hnt_pkg::POOL_SIZE; i++)
                begin
                    if (!done && !slot_busy[i])
                    begin
                        slot_busy[i] = 1'b1;
                        slot_note[i] = r.pitch;
                        slot_vel[i]  = r.velocity;
                        slot_chan[i] = r.channel;
                        slot_age[i]  = held;
                        done = 1'b1;
                    end
                end
                held++;
                want.ok = 1'b1;
                n_insert++;
            end
            else
            begin
                n_full_reject++;
            end
        end
        else if (slot >= 0)
        begin
            // Note off for a held pitch frees its slot entirely.
            leaving = slot_age[slot];
            slot_busy[slot] = 1'b0;
            slot_note[slot] = '0;
            slot_vel[slot]  = '0;
            slot_chan[slot] = '0;
            slot_age[slot]  = 0;
            close_age_gap(leaving);
            held--;
            want.ok = 1'b1;
            n_remove++;
        end
        else
        begin
            n_miss++;
        end

        // Summarize the pool after the request.
        any = 1'b0;
        for (int i = 0; i < hnt_pkg::POOL_SIZE; i++)
        begin
            if (slot_busy[i])
            begin
                if (!any || slot_note[i] < want.lowest_pitch)
                    want.lowest_pitch = slot_note[i];
                if (!any || slot_note[i] > want.highest_pitch)
                    want.highest_pitch = slot_note[i];
                any = 1'b1;
                if (slot_age[i] + 1 == held)
                begin
                    want.newest_pitch    = slot_note[i];
                    want.newest_velocity = slot_vel[i];
                    want.newest_channel  = slot_chan[i];
                end
            end
        end
        want.held_count = held[hnt_pkg::HELD_W-1:0];
        pending_rsp.push_back(want);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Check one accepted response against the oldest prediction.
    function void check_response(hnt_pkg::rsp_t got);
        hnt_pkg::rsp_t want;
        if (pending_rsp.size() == 0)
        begin
            errors++;
            $display("%0t: response %h arrived with no request waiting", $time, got);
            return;
        end
        want = pending_rsp.pop_front();
        n_checked++;
        compare_field("ok", 8'(want.ok), 8'(got.ok));
        compare_field("held_count", 8'(want.held_count), 8'(got.held_count));
        compare_field("lowest_pitch", 8'(want.lowest_pitch), 8'(got.lowest_pitch));
        compare_field("highest_pitch", 8'(want.highest_pitch), 8'(got.highest_pitch));
        compare_field("newest_pitch", 8'(want.newest_pitch), 8'(got.newest_pitch));
        compare_field("newest_velocity", 8'(want.newest_velocity),
                      8'(got.newest_velocity));
        compare_field("newest_channel", 8'(want.newest_channel),
                      8'(got.newest_channel));
    endfunction

    // A held pitch to aim a note off at, or any pitch when the pool is empty.
    function logic [6:0] pick_held();
        logic [6:0] held_list[$];
        for (int i = 0; i < hnt_pkg::POOL_SIZE; i++)
        begin
            if (slot_busy[i])
                held_list.push_back(slot_note[i]);
        end
        if (held_list.size() == 0)
            return 7'($urandom_range(0, 127));
        return held_list[$urandom_range(0, held_list.size() - 1)];
    endfunction
endclass

module tb;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1424;
    localparam int SETTLE       = 2 * hnt_pkg::POOL_SIZE + 8;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    hnt_pkg::req_t req_data;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    hnt_pkg::rsp_t rsp_data;
    bit            calm = 1'b0;
    int            cycles = 0;
    note_board     board;

    held_note_tracker_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The response side stalls at random, except during the calm stretch.
    always @(posedge clk)
        rsp_stall <= !calm && ($urandom_range(99) < 16);

    // Note every accepted request and check every accepted response.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && req_valid && req_stall === 1'b0)
            board.note_request(req_data);
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && !rsp_stall)
            board.check_response(rsp_data);
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("held_note_tracker_top verification failed");
            $finish;
        end
    end

    // Present one request, after an optional idle gap, and hold it until accepted.
    task automatic send_request(input hnt_pkg::req_t r);
        int gap;
        gap = (!calm && $urandom_range(99) < 16) ? $urandom_range(1, 40) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
    endtask

    task automatic play(input logic kind, input int p, input int v, input int c);
        hnt_pkg::req_t r;
        r.req_type = kind;
        r.pitch    = 7'(p);
        r.velocity = 7'(v);
        r.channel  = 4'(c);
        send_request(r);
    endtask

    // Hold off new requests until every predicted response has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int         n;
        logic [6:0] p;
        bit         fill;
        int         base;
        bit         turn_on;
        board     = new();
        req_valid = 1'b0;
        req_data  = '0;
        rst_n     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pool, extremes, refresh, misses, a full pool.
        play(hnt_pkg::REQ_NOTE_OFF, 0, $urandom_range(0, 127), $urandom_range(0, 15));
        play(hnt_pkg::REQ_NOTE_ON, 127, 127, 15);
        play(hnt_pkg::REQ_NOTE_ON, 0, 0, 0);
        play(hnt_pkg::REQ_NOTE_ON, 127, 1, 5);
        play(hnt_pkg::REQ_NOTE_OFF, 42, 127, 15);
        play(hnt_pkg::REQ_NOTE_OFF, 127, $urandom_range(0, 127), $urandom_range(0, 15));
        play(hnt_pkg::REQ_NOTE_OFF, 0, $urandom_range(0, 127), $urandom_range(0, 15));
        for (n = 0; n < hnt_pkg::POOL_SIZE; n++)
            play(hnt_pkg::REQ_NOTE_ON, 5 + 7 * n, 127 - n, n);
        play(hnt_pkg::REQ_NOTE_ON, 111, 99, 9);
        play(hnt_pkg::REQ_NOTE_ON, 5, 64, 10);
        play(hnt_pkg::REQ_NOTE_OFF, 61, 0, 0);
        wait_drained();

        // Random: alternating fill and drain phases around a moving pitch window.
        fill = 1'b0;
        base = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 60 == 0)
            begin
                fill = !fill;
                base = $urandom_range(0, 104);
            end
            if (n % 250 == 125)
                wait_drained();
            calm = (n >= 500 && n < 700);
            turn_on = $urandom_range(99) < (fill ? 70 : 30);
            if (!turn_on && $urandom_range(99) < 60)
                p = board.pick_held();
            else if ($urandom_range(99) < 10)
                p = 7'($urandom_range(0, 127));
            else
                p = 7'(base + $urandom_range(0, 23));
            play(turn_on ? hnt_pkg::REQ_NOTE_ON : hnt_pkg::REQ_NOTE_OFF, int'(p),
                 $urandom_range(0, 127), $urandom_range(0, 15));
        end
        calm = 1'b0;

        // Drain and let the block settle.
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d requests: %0d inserts, %0d refreshes, %0d rejected on a full pool,",
                 board.n_requests, board.n_insert, board.n_refresh, board.n_full_reject);
        $display("%0d removals, %0d note-offs for unheld pitches; %0d responses checked.",
                 board.n_remove, board.n_miss, board.n_checked);
        if (board.pending_rsp.size() != 0)
            $display("%0t: %0d responses never arrived", $time, board.pending_rsp.size());
        if (board.errors == 0 && board.pending_rsp.size() == 0)
            $display("held_note_tracker_top verification clean");
        else
            $display("held_note_tracker_top verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/hnt_pkg.sv
hw/rtl/hnt_slot_store.sv
hw/rtl/hnt_ctrl.sv
hw/rtl/held_note_tracker_top.sv
hw/rtl/hnt_checker.sv
bench/tb.sv
